// ----- rtl/core/rarmt_pkg.sv -----
`default_nettype none
package rarmt_pkg;

  localparam int DEF_LEAVES = 1024;

  localparam logic [31:0] INIT_NODE   = 32'd1000000000;
  localparam logic [31:0] QUERY_START = 32'h7FFF_FFFF;

  // item modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // node operations run by the node unit
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_PULL,
    OP_ADD,
    OP_LEAF
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] data;
  } node_req_t;

  // signed minimum of two words
  function automatic logic [31:0] smin(input logic [31:0] a, input logic [31:0] b);
    smin = ($signed(a) < $signed(b)) ? a : b;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/range_add_range_min_tree.sv -----
`default_nettype none
// Lazy segment tree: load one element, add over a span, minimum over a span.
// Input: an item is taken at a clock edge with start high and busy low;
// fields mode, left_index, right_index, load_value, add_amount.
// Result: done is high for one cycle with min_value and bad_range; the
// receiver always takes it, there is no stall on the result side.
// Configuration: element_count_write loads element_count_data; write only
// while busy is low and no result is outstanding.
// Rejected spans, rejected load indexes and mode three answer in the cycle
// after the transfer. Other items run a sequence of node operations on the
// node unit, one at a time: a load pushes down the path to its leaf, writes
// the leaf and pulls up each level; a span add or query pushes down both
// boundary paths and walks the span, and a span add then pulls up both
// paths. The single node unit and its two memories set the pace.
// After reset the node memories are swept, one node a cycle over 2 x span
// nodes; busy stays high until done.
module range_add_range_min_tree #(
  parameter int LEAVES = rarmt_pkg::DEF_LEAVES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         mode,
  input  wire logic [9:0]         left_index,
  input  wire logic [9:0]         right_index,
  input  wire logic signed [31:0] load_value,
  input  wire logic signed [31:0] add_amount,
  input  wire logic               element_count_write,
  input  wire logic [10:0]        element_count_data,
  output logic                    done,
  output logic signed [31:0]      min_value,
  output logic                    bad_range
);

  localparam int H  = $clog2(LEAVES);
  localparam int NW = H + 1;
  localparam int LW = $clog2(H + 1);
  localparam int CW = ($clog2(LEAVES + 1) > 11) ? $clog2(LEAVES + 1) : 11;

  typedef enum logic [2:0] {W_IDLE, W_DOWN, W_LEAF, W_LOOP, W_UP, W_FIN} wstate_t;

  wstate_t       state;
  logic [10:0]   element_count;
  logic [1:0]    op_mode;
  logic [NW-1:0] l;
  logic [NW-1:0] r;
  logic [NW-1:0] a;
  logic [NW-1:0] b;
  logic [LW-1:0] lvl;
  logic          side;
  logic [31:0]   data;
  logic [31:0]   lo;
  logic [31:0]   hi;
  logic          acc_lo;
  logic          acc_hi;

  logic                 ready;
  logic [31:0]          last_min;
  logic                 issue;
  rarmt_pkg::node_req_t ireq;
  logic [NW-1:0]        inode;

  logic [CW-1:0] cnt;
  logic [CW-1:0] left_ext;
  logic [CW-1:0] right_ext;
  logic          accept;
  logic          bad;
  logic          is_load;
  logic          is_add;
  logic [NW-1:0] mask;
  logic          cond_l;
  logic          cond_r;

  assign cnt = (CW'(element_count) > CW'(LEAVES)) ? CW'(LEAVES) : CW'(element_count);
  assign left_ext  = CW'(left_index);
  assign right_ext = CW'(right_index);
  assign accept    = start && !busy;
  assign busy      = (state != W_IDLE) || !ready;
  assign is_load   = (op_mode == rarmt_pkg::MODE_LOAD);
  assign is_add    = (op_mode == rarmt_pkg::MODE_ADD);
  assign mask      = (NW'(1) << lvl) - NW'(1);
  assign cond_l    = is_load || ((l & mask) != '0);
  assign cond_r    = !is_load && ((r & mask) != mask);

  // span check at transfer
  always_comb begin
    case (mode)
      rarmt_pkg::MODE_LOAD: bad = (left_ext >= cnt);
      rarmt_pkg::MODE_ADD, rarmt_pkg::MODE_QUERY:
        bad = (left_index > right_index) || (right_ext >= cnt);
      default: bad = 1'b0;
    endcase
  end

  // node operation to issue in this step
  always_comb begin
    issue     = 1'b0;
    ireq.op   = rarmt_pkg::OP_PUSH;
    ireq.data = data;
    inode     = l;
    case (state)
      W_DOWN, W_UP: begin
        inode   = side ? (r >> lvl) : (l >> lvl);
        issue   = ready && (side ? cond_r : cond_l);
        ireq.op = (state == W_DOWN) ? rarmt_pkg::OP_PUSH : rarmt_pkg::OP_PULL;
      end
      W_LEAF: begin
        issue   = ready;
        ireq.op = rarmt_pkg::OP_LEAF;
      end
      W_LOOP: begin
        ireq.op = is_add ? rarmt_pkg::OP_ADD : rarmt_pkg::OP_PUSH;
        if (!side) begin
          inode = a;
          issue = ready && (a <= b) && a[0];
        end else begin
          inode = b;
          issue = ready && !b[0];
        end
      end
      default: begin
      end
    endcase
  end

  rarmt_node_unit #(.LEAVES(LEAVES)) u_node (
    .clk      (clk),
    .rst      (rst),
    .start    (issue),
    .req      (ireq),
    .node     (inode),
    .ready    (ready),
    .last_min (last_min)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= 11'd1024;
    end else if (element_count_write) begin
      element_count <= element_count_data;
    end
  end

  // span walker
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= W_IDLE;
      done   <= 1'b0;
      acc_lo <= 1'b0;
      acc_hi <= 1'b0;
    end else begin
      done <= 1'b0;
      // fold the last query push into the running minima
      if (ready && acc_lo) begin
        lo     <= rarmt_pkg::smin(lo, last_min);
        acc_lo <= 1'b0;
      end
      if (ready && acc_hi) begin
        hi     <= rarmt_pkg::smin(last_min, hi);
        acc_hi <= 1'b0;
      end
      case (state)
        W_IDLE: begin
          if (accept) begin
            op_mode <= mode;
            data    <= (mode == rarmt_pkg::MODE_LOAD) ? load_value : add_amount;
            l       <= NW'(1 << H) + NW'(left_index);
            r       <= NW'(1 << H) + NW'(right_index);
            lvl     <= LW'(H);
            side    <= 1'b0;
            lo      <= rarmt_pkg::QUERY_START;
            hi      <= rarmt_pkg::QUERY_START;
            if (bad || (mode != rarmt_pkg::MODE_LOAD && mode != rarmt_pkg::MODE_ADD &&
                        mode != rarmt_pkg::MODE_QUERY)) begin
              done      <= 1'b1;
              min_value <= '0;
              bad_range <= bad;
            end else begin
              state <= W_DOWN;
            end
          end
        end
        W_DOWN: begin
          if (ready) begin
            side <= !side;
            if (side) begin
              if (lvl == LW'(1)) begin
                a     <= l;
                b     <= r;
                state <= is_load ? W_LEAF : W_LOOP;
              end else begin
                lvl <= lvl - LW'(1);
              end
            end
          end
        end
        W_LEAF: begin
          if (ready) begin
            lvl   <= LW'(1);
            side  <= 1'b0;
            state <= W_UP;
          end
        end
        W_LOOP: begin
          if (ready) begin
            if (!side) begin
              if (a > b) begin
                lvl   <= LW'(1);
                state <= is_add ? W_UP : W_FIN;
              end else begin
                a      <= a[0] ? ((a >> 1) + NW'(1)) : (a >> 1);
                side   <= 1'b1;
                acc_lo <= issue && !is_add;
              end
            end else begin
              b      <= b[0] ? (b >> 1) : ((b >> 1) - NW'(1));
              side   <= 1'b0;
              acc_hi <= issue && !is_add;
            end
          end
        end
        W_UP: begin
          if (ready) begin
            side <= !side;
            if (side) begin
              if (lvl == LW'(H)) begin
                state <= W_FIN;
              end else begin
                lvl <= lvl + LW'(1);
              end
            end
          end
        end
        W_FIN: begin
          if (ready && !acc_lo && !acc_hi) begin
            done      <= 1'b1;
            bad_range <= 1'b0;
            min_value <= (op_mode == rarmt_pkg::MODE_QUERY) ? rarmt_pkg::smin(lo, hi) : '0;
            state     <= W_IDLE;
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == W_IDLE)) else $error("result while a walk is running");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy || done) else $error("transfer left no trace");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && bad_range) |-> (min_value == '0)) else $error("rejected item with value");

endmodule
`default_nettype wire

// ----- rtl/core/rarmt_node_unit.sv -----
`default_nettype none
module rarmt_node_unit #(
  parameter int LEAVES = rarmt_pkg::DEF_LEAVES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire rarmt_pkg::node_req_t           req,
  input  wire logic [$clog2(LEAVES):0]        node,
  output logic                                ready,
  output logic [31:0]                         last_min
);

  localparam int H     = $clog2(LEAVES);
  localparam int NW    = H + 1;
  localparam int DEPTH = 2 << H;

  typedef enum logic [3:0] {
    U_CLEAR, U_IDLE, U_A0, U_A1, U_P0, U_P1, U_P2, U_P3, U_PW
  } ustate_t;

  ustate_t     state;
  logic [NW-1:0] cur;
  logic [NW-1:0] parent;
  logic [NW-1:0] clr_addr;
  logic        pull;
  logic        second;
  logic [31:0] pend;
  logic [31:0] save;
  logic [31:0] data;

  // node minimum and pending add memories
  logic [31:0] min_mem  [DEPTH];
  logic [31:0] pend_mem [DEPTH];
  logic [31:0] min_rd;
  logic [31:0] pend_rd;

  logic          min_we;
  logic [NW-1:0] min_waddr;
  logic [31:0]   min_wdata;
  logic          pend_we;
  logic [NW-1:0] pend_waddr;
  logic [31:0]   pend_wdata;
  logic [NW-1:0] min_raddr;
  logic [NW-1:0] pend_raddr;

  logic [31:0]   new_min;
  logic [NW-1:0] child;
  logic          finish;
  logic [31:0]   fin_min;

  assign ready   = (state == U_IDLE);
  assign new_min = min_rd + pend_rd;
  assign child   = {cur[NW-2:0], 1'b0};
  assign finish  = ((state == U_P1) && cur[NW-1]) || (state == U_P3);
  assign fin_min = (state == U_P1) ? new_min : last_min;

  // memory port selection
  always_comb begin
    min_we     = 1'b0;
    min_waddr  = cur;
    min_wdata  = new_min;
    pend_we    = 1'b0;
    pend_waddr = cur;
    pend_wdata = '0;
    min_raddr  = cur;
    pend_raddr = cur;
    case (state)
      U_CLEAR: begin
        min_we     = 1'b1;
        min_waddr  = clr_addr;
        min_wdata  = rarmt_pkg::INIT_NODE;
        pend_we    = 1'b1;
        pend_waddr = clr_addr;
      end
      U_IDLE: begin
        if (start && (req.op == rarmt_pkg::OP_LEAF)) begin
          min_we     = 1'b1;
          min_waddr  = node;
          min_wdata  = req.data;
          pend_we    = 1'b1;
          pend_waddr = node;
        end
      end
      U_A1: begin
        pend_we    = 1'b1;
        pend_wdata = pend_rd + data;
      end
      U_P1: begin
        min_we     = 1'b1;
        pend_we    = 1'b1;
        pend_raddr = child;
      end
      U_P2: begin
        pend_we    = 1'b1;
        pend_waddr = child;
        pend_wdata = pend_rd + pend;
        pend_raddr = child | NW'(1);
      end
      U_P3: begin
        pend_we    = 1'b1;
        pend_waddr = child | NW'(1);
        pend_wdata = pend_rd + pend;
      end
      U_PW: begin
        min_we    = 1'b1;
        min_waddr = parent;
        min_wdata = rarmt_pkg::smin(save, last_min);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (min_we) begin
      min_mem[min_waddr] <= min_wdata;
    end
    if (pend_we) begin
      pend_mem[pend_waddr] <= pend_wdata;
    end
    min_rd  <= min_mem[min_raddr];
    pend_rd <= pend_mem[pend_raddr];
  end

  // operation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= U_CLEAR;
      clr_addr <= '0;
      pull     <= 1'b0;
      second   <= 1'b0;
    end else begin
      case (state)
        U_CLEAR: begin
          clr_addr <= clr_addr + NW'(1);
          if (clr_addr == {NW{1'b1}}) begin
            state <= U_IDLE;
          end
        end
        U_IDLE: begin
          if (start) begin
            data   <= req.data;
            parent <= node;
            pull   <= 1'b0;
            second <= 1'b0;
            case (req.op)
              rarmt_pkg::OP_PUSH: begin
                cur   <= node;
                state <= U_P0;
              end
              rarmt_pkg::OP_PULL: begin
                cur   <= {node[NW-2:0], 1'b0};
                pull  <= 1'b1;
                state <= U_P0;
              end
              rarmt_pkg::OP_ADD: begin
                cur   <= node;
                state <= U_A0;
              end
              default: begin
              end
            endcase
          end
        end
        U_A0: state <= U_A1;
        U_A1: state <= U_IDLE;
        U_P0: state <= U_P1;
        U_P1: begin
          last_min <= new_min;
          pend     <= pend_rd;
          if (!cur[NW-1]) begin
            state <= U_P2;
          end
        end
        U_P2: state <= U_P3;
        U_PW: state <= U_IDLE;
        default: state <= U_IDLE;
      endcase
      // end of one push: next child, parent write or done
      if (finish) begin
        if (pull && !second) begin
          save   <= fin_min;
          cur    <= cur | NW'(1);
          second <= 1'b1;
          state  <= U_P0;
        end else if (pull) begin
          state <= U_PW;
        end else begin
          state <= U_IDLE;
        end
      end
    end
  end

  a_start_when_ready: assert property (@(posedge clk) disable iff (rst)
    start |-> ready) else $error("node op issued while unit busy");
  a_child_inner: assert property (@(posedge clk) disable iff (rst)
    (state == U_P2) |-> !cur[NW-1]) else $error("child push on a leaf");
  a_pw_pull: assert property (@(posedge clk) disable iff (rst)
    (state == U_PW) |-> (pull && second)) else $error("parent write outside pull");
  a_pull_inner: assert property (@(posedge clk) disable iff (rst)
    (start && (req.op == rarmt_pkg::OP_PULL)) |-> !node[NW-1])
    else $error("pull of a leaf");

endmodule
`default_nettype wire

// ----- sim/tree_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tree_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [1:0]         mode,
  input  wire logic [9:0]         left_index,
  input  wire logic [9:0]         right_index,
  input  wire logic signed [31:0] load_value,
  input  wire logic signed [31:0] add_amount,
  input  wire logic               element_count_write,
  input  wire logic [10:0]        element_count_data,
  input  wire logic               done,
  input  wire logic signed [31:0] min_value,
  input  wire logic               bad_range,
  output int                      fail_count,
  output int                      pending_count
);

  localparam int SPAN = 1024;
  localparam int HEIGHT = 10;

  typedef struct packed {
    logic [31:0] minimum;
    logic        bad;
  } answer_t;

  logic [31:0] node_min [0:2*SPAN-1];
  logic [31:0] node_add [0:2*SPAN-1];
  logic [10:0] used_count;
  answer_t     answers [$];

  assign pending_count = answers.size();

  function automatic logic [31:0] lower(logic [31:0] a, logic [31:0] b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  // apply a node's pending add to itself and hand it to the children
  function automatic void push_down(int k);
    if (k < 1 || k >= 2 * SPAN) return;
    node_min[k] += node_add[k];
    if (k < SPAN) begin
      node_add[2*k] += node_add[k];
      node_add[2*k+1] += node_add[k];
    end
    node_add[k] = '0;
  endfunction

  function automatic void pull_up(int k);
    if (k < 1 || k >= SPAN) return;
    push_down(2*k);
    push_down(2*k+1);
    node_min[k] = lower(node_min[2*k], node_min[2*k+1]);
  endfunction

  function automatic answer_t apply_item(logic [1:0] m, int lft, int rgt,
                                         logic [31:0] val, logic [31:0] amt);
    answer_t res;
    int count;
    int a;
    int b;
    int l;
    int r;
    logic [31:0] lo;
    logic [31:0] hi;
    res = '0;
    count = (used_count > SPAN) ? SPAN : int'(used_count);
    if (m == rarmt_pkg::MODE_LOAD) begin
      if (lft >= count) res.bad = 1'b1;
      else begin
        l = lft + SPAN;
        for (int i = HEIGHT; i > 0; i--) push_down(l >> i);
        node_min[l] = val;
        node_add[l] = '0;
        for (int i = 1; i <= HEIGHT; i++) pull_up(l >> i);
      end
    end else if (m == rarmt_pkg::MODE_ADD || m == rarmt_pkg::MODE_QUERY) begin
      if (lft > rgt || rgt >= count) res.bad = 1'b1;
      else begin
        l = lft + SPAN;
        r = rgt + SPAN;
        // push boundary paths top down
        for (int i = HEIGHT; i > 0; i--) begin
          if (((l >> i) << i) != l) push_down(l >> i);
          if ((((r + 1) >> i) << i) != r + 1) push_down(r >> i);
        end
        a = l;
        b = r;
        lo = rarmt_pkg::QUERY_START;
        hi = rarmt_pkg::QUERY_START;
        while (a <= b) begin
          if ((a & 1) == 0) a = a / 2;
          else begin
            if (m == rarmt_pkg::MODE_ADD) node_add[a] += amt;
            else begin
              push_down(a);
              lo = lower(lo, node_min[a]);
            end
            a = a / 2 + 1;
          end
          if ((b & 1) == 0) begin
            if (m == rarmt_pkg::MODE_ADD) node_add[b] += amt;
            else begin
              push_down(b);
              hi = lower(node_min[b], hi);
            end
            b = b / 2 - 1;
          end else b = b / 2;
        end
        if (m == rarmt_pkg::MODE_ADD) begin
          for (int i = 1; i <= HEIGHT; i++) begin
            if (((l >> i) << i) != l) pull_up(l >> i);
            if ((((r + 1) >> i) << i) != r + 1) pull_up(r >> i);
          end
        end else res.minimum = lower(lo, hi);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // watch transfers, predict and compare
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      for (int k = 0; k < 2 * SPAN; k++) begin
        node_min[k] = rarmt_pkg::INIT_NODE;
        node_add[k] = '0;
      end
      used_count = 11'd1024;
      answers.delete();
      fail_count = 0;
    end else begin
      if (element_count_write) used_count = element_count_data;
      if (done) begin
        if (answers.size() == 0) report_mismatch("result with nothing expected");
        else begin
          want = answers.pop_front();
          if (min_value !== want.minimum)
            report_mismatch($sformatf("min_value %0d want %0d", min_value,
                                      $signed(want.minimum)));
          if (bad_range !== want.bad)
            report_mismatch($sformatf("bad_range %b want %b", bad_range, want.bad));
        end
      end
      if (start && !busy)
        answers.push_back(apply_item(mode, left_index, right_index, load_value,
                                     add_amount));
    end
  end
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode = '0;
  logic [9:0] left_index = '0;
  logic [9:0] right_index = '0;
  logic signed [31:0] load_value = '0;
  logic signed [31:0] add_amount = '0;
  logic element_count_write = 1'b0;
  logic [10:0] element_count_data = '0;
  logic done;
  logic signed [31:0] min_value;
  logic bad_range;
  int fail_count;
  int pending_count;
  int idle_pct = 0;
  int quiet_cycles = 0;
  logic [10:0] count_now = 11'd1024;

  range_add_range_min_tree dut (.*);
  tree_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog on cycles with no transfer and no result
  always @(posedge clk) begin
    if ((start && !busy) || done || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("FAIL range_add_range_min_tree");
      $finish;
    end
  end

  // start stays high between back to back items and drops only while idling or in drain
  task automatic send(logic [1:0] m, int l, int r, logic [31:0] v, logic [31:0] a);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    left_index <= 10'(l);
    right_index <= 10'(r);
    load_value <= v;
    add_amount <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_count(logic [10:0] c);
    drain();
    element_count_write <= 1'b1;
    element_count_data <= c;
    count_now = c;
    @(posedge clk);
    element_count_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] any_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // mostly valid spans under the current count, sometimes anything
  task automatic random_item();
    int lim;
    int l;
    int r;
    lim = (count_now == 0) ? 1 : ((count_now > 1024) ? 1024 : int'(count_now));
    l = $urandom_range(lim - 1);
    r = $urandom_range(lim - 1, l);
    if ($urandom_range(9) == 0) begin
      l = $urandom_range(1023);
      r = $urandom_range(1023);
    end
    send($urandom_range(9) == 0 ? rarmt_pkg::MODE_NONE : 2'($urandom_range(2)), l, r,
         any_word(), any_word());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, each mode and rejected cases
    send(rarmt_pkg::MODE_QUERY, 0, 1023, 0, 0);
    send(rarmt_pkg::MODE_LOAD, 0, 0, 32'h8000_0000, 0);
    send(rarmt_pkg::MODE_LOAD, 1023, 0, 32'h7FFF_FFFF, 0);
    send(rarmt_pkg::MODE_QUERY, 0, 1023, 0, 0);
    send(rarmt_pkg::MODE_ADD, 0, 1023, 0, 32'hFFFF_FFFF);
    send(rarmt_pkg::MODE_QUERY, 0, 0, 0, 0);
    send(rarmt_pkg::MODE_ADD, 1, 1022, 0, 32'h7FFF_FFFF);
    send(rarmt_pkg::MODE_QUERY, 1, 1022, 0, 0);
    send(rarmt_pkg::MODE_QUERY, 1023, 1023, 0, 0);
    send(rarmt_pkg::MODE_ADD, 5, 4, 0, 1);
    send(rarmt_pkg::MODE_QUERY, 700, 3, 0, 0);
    send(rarmt_pkg::MODE_NONE, 1023, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(rarmt_pkg::MODE_LOAD, 512, 1023, 32'h5555_AAAA, 32'hAAAA_5555);
    send(rarmt_pkg::MODE_QUERY, 511, 513, 0, 0);
    set_count(11'd0);
    send(rarmt_pkg::MODE_LOAD, 0, 0, 1, 0);
    send(rarmt_pkg::MODE_QUERY, 0, 0, 0, 0);
    set_count(11'd2047);
    send(rarmt_pkg::MODE_QUERY, 0, 1023, 0, 0);
    set_count(11'd1);
    send(rarmt_pkg::MODE_QUERY, 0, 0, 0, 0);
    send(rarmt_pkg::MODE_ADD, 0, 1, 0, 3);
    send(rarmt_pkg::MODE_LOAD, 1, 0, 9, 0);
    // random phases over idling and count settings
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph % 4 == 1) ? 57 : ((ph % 4 == 3) ? 19 : 0);
      case (ph)
        0: set_count(11'd1024);
        2: set_count(11'd17);
        4: set_count(11'($urandom_range(1, 1023)));
        6: set_count(11'd1);
        7: set_count(11'd1024);
        default: ;
      endcase
      for (int n = 0; n < 48; n++) random_item();
      if (ph == 3) drain();
    end
    drain();
    if (fail_count == 0) $display("PASS range_add_range_min_tree");
    else $display("FAIL range_add_range_min_tree");
    $finish;
  end
endmodule
`default_nettype wire

// ----- range_add_range_min_tree.f -----
rtl/core/rarmt_pkg.sv
rtl/core/rarmt_node_unit.sv
rtl/core/range_add_range_min_tree.sv
sim/tree_checker.sv
sim/tb.sv
